[rtl/fanesc_pkg.sv]
// ----------------------------------------------------------------------------
// Fan ESC sequencer package
// Shared types, codes and constants for the fan adhesion ESC sequencer.
// ----------------------------------------------------------------------------
package fanesc_pkg;

  // Fixed build choices of the sequencer.
  localparam logic [15:0] RAMP_PERIOD_MS = 16'd20;
  localparam logic [15:0] ARM_TIME_MS    = 16'd2000;
  localparam logic        OUTPUT_ENABLE  = 1'b1;
  localparam logic        PWM_MAPPED     = 1'b1;

  // ESC modes as reported on the result channel.
  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_ARMING    = 3'd1,
    MODE_PRECHARGE = 3'd2,
    MODE_BOOST     = 3'd3,
    MODE_HOLD      = 3'd4,
    MODE_RAMP      = 3'd5,
    MODE_FAILSAFE  = 3'd6
  } esc_mode_e;

  // Track phase codes carried by an input beat.
  localparam logic [3:0] PH_FAILSAFE  = 4'd0;
  localparam logic [3:0] PH_GROUND    = 4'd1;
  localparam logic [3:0] PH_APPROACH  = 4'd2;
  localparam logic [3:0] PH_PRECHARGE = 4'd3;
  localparam logic [3:0] PH_UP        = 4'd4;
  localparam logic [3:0] PH_WALL      = 4'd5;
  localparam logic [3:0] PH_CYLINDER  = 4'd6;
  localparam logic [3:0] PH_DOWN      = 4'd7;
  localparam logic [3:0] PH_RECOVERY  = 4'd8;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MIN_PULSE       = 3'd0,
    REG_HOLD_PULSE      = 3'd1,
    REG_PRECHARGE_PULSE = 3'd2,
    REG_BOOST_PULSE     = 3'd3,
    REG_RISK_LIMIT      = 3'd4,
    REG_BOOST_TIME      = 3'd5,
    REG_CONFIRM_TIME    = 3'd6,
    REG_RAMP_STEP       = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] min_pulse_us;
    logic [15:0] hold_pulse_us;
    logic [15:0] precharge_pulse_us;
    logic [15:0] boost_pulse_us;
    logic [15:0] risk_limit;
    logic [15:0] boost_time_ms;
    logic [15:0] confirm_time_ms;
    logic [15:0] ramp_step_us;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_pulse_us:       16'd1000,
    hold_pulse_us:      16'd1400,
    precharge_pulse_us: 16'd1200,
    boost_pulse_us:     16'd1600,
    risk_limit:         16'd500,
    boost_time_ms:      16'd300,
    confirm_time_ms:    16'd200,
    ramp_step_us:       16'd20
  };

  // Sequencer state carried from tick to tick.
  typedef struct packed {
    esc_mode_e   mode;
    logic [15:0] mode_ms;
    logic [15:0] boost_ms;
    logic [15:0] confirm_ms;
    logic [15:0] ramp_ms;
    logic [15:0] pulse_us;
  } seq_state_t;

  // Input and result beats.
  typedef struct packed {
    logic [3:0]  wall_phase;
    logic [15:0] slip_risk;
    logic [15:0] tick_ms;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  esc_mode;
    logic [15:0] request_pulse_us;
    logic [15:0] drive_pulse_us;
  } out_beat_t;

endpackage

[rtl/fanesc_step.sv]
// ----------------------------------------------------------------------------
// Fan ESC sequencer tick update
// Combinational next state of the sequencer for one control tick.
// ----------------------------------------------------------------------------
module fanesc_step
  import fanesc_pkg::*;
(
  input  seq_state_t st_i,
  input  cfg_t       cfg_i,
  input  in_beat_t   beat_i,
  output seq_state_t st_o
);

  // Mode entry: a new mode clears the mode, boost and ramp timers, every entry loads the pulse.
  function automatic seq_state_t go_mode(seq_state_t s, esc_mode_e nxt,
                                         logic [15:0] pulse);
    seq_state_t r;
    r = s;
    if (s.mode != nxt) begin
      r.mode     = nxt;
      r.mode_ms  = '0;
      r.boost_ms = '0;
      r.ramp_ms  = '0;
    end
    r.pulse_us = pulse;
    return r;
  endfunction

  seq_state_t  st;
  logic        arm_wait;
  logic [15:0] dt;
  logic [15:0] floor_us;

  assign dt       = beat_i.tick_ms;
  assign floor_us = cfg_i.min_pulse_us + cfg_i.ramp_step_us;

  // One tick: arming delay first, then the phase decides the mode.
  always_comb begin
    st       = st_i;
    arm_wait = 1'b0;
    st.mode_ms = st.mode_ms + dt;

    if (OUTPUT_ENABLE && st.mode == MODE_ARMING) begin
      st.pulse_us = cfg_i.min_pulse_us;
      if (st.mode_ms < ARM_TIME_MS) begin
        arm_wait = 1'b1;
      end else begin
        st = go_mode(st, MODE_OFF, cfg_i.min_pulse_us);
      end
    end

    if (!arm_wait) begin
      case (beat_i.wall_phase) inside
        PH_FAILSAFE: begin
          st = go_mode(st, MODE_FAILSAFE, cfg_i.hold_pulse_us);
        end
        PH_GROUND, PH_APPROACH: begin
          st.confirm_ms = '0;
          st = go_mode(st, MODE_OFF, cfg_i.min_pulse_us);
        end
        PH_PRECHARGE: begin
          st.confirm_ms = '0;
          st = go_mode(st, MODE_PRECHARGE, cfg_i.precharge_pulse_us);
        end
        [PH_UP:PH_DOWN]: begin
          st.confirm_ms = '0;
          if (beat_i.slip_risk > cfg_i.risk_limit && beat_i.wall_phase != PH_DOWN &&
              st.mode != MODE_BOOST) begin
            st = go_mode(st, MODE_BOOST, cfg_i.boost_pulse_us);
          end else if (st.mode == MODE_BOOST) begin
            st.boost_ms = st.boost_ms + dt;
            if (st.boost_ms >= cfg_i.boost_time_ms) begin
              st = go_mode(st, MODE_HOLD, cfg_i.hold_pulse_us);
            end
          end else begin
            st = go_mode(st, MODE_HOLD, cfg_i.hold_pulse_us);
          end
        end
        PH_RECOVERY: begin
          st.confirm_ms = st.confirm_ms + dt;
          if (st.confirm_ms < cfg_i.confirm_time_ms) begin
            st = go_mode(st, MODE_HOLD, cfg_i.hold_pulse_us);
          end else begin
            if (st.mode != MODE_RAMP) begin
              st = go_mode(st, MODE_RAMP, cfg_i.hold_pulse_us);
            end
            st.ramp_ms = st.ramp_ms + dt;
            if (st.ramp_ms >= RAMP_PERIOD_MS) begin
              st.ramp_ms = '0;
              if (st.pulse_us > floor_us) begin
                st.pulse_us = st.pulse_us - cfg_i.ramp_step_us;
              end else begin
                st = go_mode(st, MODE_OFF, cfg_i.min_pulse_us);
              end
            end
          end
        end
        default: begin
          st = go_mode(st, MODE_OFF, cfg_i.min_pulse_us);
        end
      endcase
    end
  end

  assign st_o = st;

endmodule

[rtl/fan_adhesion_esc_sequencer_core.sv]
// ----------------------------------------------------------------------------
// Fan adhesion ESC sequencer
// Tracks the fan ESC mode and pulse width request from per-tick track phase,
// adhesion risk and elapsed time.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                 | beat
//   in      | input     | in_valid_i / in_stall_o   | in_beat_t (phase, risk, tick)
//   out     | output    | out_valid_o / out_stall_i | out_beat_t (mode, request, drive)
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat is taken every cycle unless the input stalls; its result is registered.
// The whole tick update is one combinational pass from the state registers.
// A two-entry output stage (output register plus skid) keeps the input open
// while a result waits; the input stalls only once both entries are full.
// Reset loads the register defaults and starts the arming delay.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
module fan_adhesion_esc_sequencer_core
  import fanesc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t       cfg_q;
  seq_state_t st_q, st_d;
  out_beat_t  res;
  out_beat_t  out_q, skid_q;
  logic       out_vld_q, skid_vld_q;
  logic       in_acc;
  logic       out_free;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_MIN_PULSE:       cfg_q.min_pulse_us       <= cfg_data_i;
        REG_HOLD_PULSE:      cfg_q.hold_pulse_us      <= cfg_data_i;
        REG_PRECHARGE_PULSE: cfg_q.precharge_pulse_us <= cfg_data_i;
        REG_BOOST_PULSE:     cfg_q.boost_pulse_us     <= cfg_data_i;
        REG_RISK_LIMIT:      cfg_q.risk_limit         <= cfg_data_i;
        REG_BOOST_TIME:      cfg_q.boost_time_ms      <= cfg_data_i;
        REG_CONFIRM_TIME:    cfg_q.confirm_time_ms    <= cfg_data_i;
        REG_RAMP_STEP:       cfg_q.ramp_step_us       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Tick update.
  fanesc_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .beat_i (in_data_i),
    .st_o   (st_d)
  );

  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Sequencer state advances on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode       <= OUTPUT_ENABLE ? MODE_ARMING : MODE_OFF;
      st_q.mode_ms    <= '0;
      st_q.boost_ms   <= '0;
      st_q.confirm_ms <= '0;
      st_q.ramp_ms    <= '0;
      st_q.pulse_us   <= CFG_RESET.min_pulse_us;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  // Result of this tick.
  always_comb begin
    res.esc_mode         = st_d.mode;
    res.request_pulse_us = st_d.pulse_us;
    res.drive_pulse_us   = (OUTPUT_ENABLE && PWM_MAPPED) ? st_d.pulse_us : '0;
  end

  // Output register with skid entry.
  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[rtl/fanesc_checker.sv]
// ----------------------------------------------------------------------------
// Fan ESC sequencer checker
// Port-level assertions for the sequencer core, attached by bind.
// ----------------------------------------------------------------------------
module fanesc_checker
  import fanesc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input out_beat_t  out_data_o
);

  // A stalled result beat stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // After every accepted input beat the result output is valid in the next cycle.
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // The input only stalls after the output side held a beat back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // The driven pulse follows the request whenever the output is live.
  a_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.drive_pulse_us ==
      ((OUTPUT_ENABLE && PWM_MAPPED) ? out_data_o.request_pulse_us : 16'd0)))
    else $error("drive pulse does not match request");

endmodule

bind fan_adhesion_esc_sequencer_core fanesc_checker u_fanesc_checker (.*);

[dv/tb_fan_adhesion_esc_sequencer_core.sv]
// ----------------------------------------------------------------------------
// Fan adhesion ESC sequencer testbench
// Sends control ticks into the sequencer and predicts every result beat from
// a behavioral model of the mode and timer logic. Each field of each result
// is checked. The run covers directed arming, boost, hold, ramp and phase
// cases, register corner settings and randomized wall missions. These run
// under sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_fan_adhesion_esc_sequencer_core;
  import fanesc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  // Phase codes that the package leaves unnamed.
  localparam logic [3:0] PH_OTHER    = 4'd9;
  localparam logic [3:0] PH_TOP_CODE = 4'd15;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_e  cfg_index = REG_MIN_PULSE;
  logic [15:0] cfg_data = '0;

  // Idling controls for the sender and the receiver.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_off_left = 0;

  // Behavioral copy of the sequencer and the results it still owes.
  seq_state_t  esc_state;
  cfg_t        esc_cfg;
  out_beat_t   expected_results[$];

  int unsigned ticks_sent = 0;
  int unsigned results_checked = 0;
  int unsigned settings_applied = 0;
  int unsigned mismatches = 0;

  fan_adhesion_esc_sequencer_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk = ~clk;

  // Mode entry: a new mode clears the mode, boost and ramp timers, every entry loads the pulse.
  function automatic void enter_mode(input esc_mode_e next_mode, input logic [15:0] pulse);
    if (esc_state.mode != next_mode) begin
      esc_state.mode     = next_mode;
      esc_state.mode_ms  = '0;
      esc_state.boost_ms = '0;
      esc_state.ramp_ms  = '0;
    end
    esc_state.pulse_us = pulse;
  endfunction

  // One control tick of the sequencer; all timers wrap at 16 bits.
  function automatic out_beat_t predict_tick(input in_beat_t beat);
    out_beat_t   res;
    logic [15:0] dt;
    logic [15:0] floor_us;
    logic        arming;
    dt = beat.tick_ms;
    arming = 1'b0;
    esc_state.mode_ms = esc_state.mode_ms + dt;
    if (OUTPUT_ENABLE && esc_state.mode == MODE_ARMING) begin
      esc_state.pulse_us = esc_cfg.min_pulse_us;
      if (esc_state.mode_ms < ARM_TIME_MS) begin
        arming = 1'b1;
      end else begin
        enter_mode(MODE_OFF, esc_cfg.min_pulse_us);
      end
    end
    if (!arming) begin
      case (beat.wall_phase)
        PH_FAILSAFE: begin
          enter_mode(MODE_FAILSAFE, esc_cfg.hold_pulse_us);
        end
        PH_GROUND, PH_APPROACH: begin
          esc_state.confirm_ms = '0;
          enter_mode(MODE_OFF, esc_cfg.min_pulse_us);
        end
        PH_PRECHARGE: begin
          esc_state.confirm_ms = '0;
          enter_mode(MODE_PRECHARGE, esc_cfg.precharge_pulse_us);
        end
        PH_UP, PH_WALL, PH_CYLINDER, PH_DOWN: begin
          esc_state.confirm_ms = '0;
          if (beat.slip_risk > esc_cfg.risk_limit && beat.wall_phase != PH_DOWN &&
              esc_state.mode != MODE_BOOST) begin
            enter_mode(MODE_BOOST, esc_cfg.boost_pulse_us);
          end else if (esc_state.mode == MODE_BOOST) begin
            esc_state.boost_ms = esc_state.boost_ms + dt;
            if (esc_state.boost_ms >= esc_cfg.boost_time_ms) begin
              enter_mode(MODE_HOLD, esc_cfg.hold_pulse_us);
            end
          end else begin
            enter_mode(MODE_HOLD, esc_cfg.hold_pulse_us);
          end
        end
        PH_RECOVERY: begin
          esc_state.confirm_ms = esc_state.confirm_ms + dt;
          if (esc_state.confirm_ms < esc_cfg.confirm_time_ms) begin
            enter_mode(MODE_HOLD, esc_cfg.hold_pulse_us);
          end else begin
            floor_us = esc_cfg.min_pulse_us + esc_cfg.ramp_step_us;
            if (esc_state.mode != MODE_RAMP) begin
              enter_mode(MODE_RAMP, esc_cfg.hold_pulse_us);
            end
            esc_state.ramp_ms = esc_state.ramp_ms + dt;
            if (esc_state.ramp_ms >= RAMP_PERIOD_MS) begin
              esc_state.ramp_ms = '0;
              if (esc_state.pulse_us > floor_us) begin
                esc_state.pulse_us = esc_state.pulse_us - esc_cfg.ramp_step_us;
              end else begin
                enter_mode(MODE_OFF, esc_cfg.min_pulse_us);
              end
            end
          end
        end
        default: begin
          enter_mode(MODE_OFF, esc_cfg.min_pulse_us);
        end
      endcase
    end
    res.esc_mode         = esc_state.mode;
    res.request_pulse_us = esc_state.pulse_us;
    res.drive_pulse_us   = (OUTPUT_ENABLE && PWM_MAPPED) ? esc_state.pulse_us : 16'd0;
    return res;
  endfunction

  function automatic in_beat_t make_tick(input logic [3:0] phase, input logic [15:0] risk,
                                         input logic [15:0] dt);
    in_beat_t beat;
    beat.wall_phase = phase;
    beat.slip_risk  = risk;
    beat.tick_ms    = dt;
    return beat;
  endfunction

  // Mostly short ticks so the timers step through their thresholds.
  function automatic logic [15:0] pick_dt();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 16'($urandom);
    if (roll < 10) return 16'd0;
    return 16'($urandom_range(1, 40));
  endfunction

  // Risk values cluster around the boost limit.
  function automatic logic [15:0] pick_risk();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return esc_cfg.risk_limit;
      2: return esc_cfg.risk_limit + 16'd1;
      default: return 16'($urandom_range(0, esc_cfg.risk_limit));
    endcase
  endfunction

  // Settings in which wall missions reach boost, hold and the end of the ramp.
  function automatic cfg_t pick_mission_cfg();
    cfg_t c;
    c.min_pulse_us       = 16'($urandom_range(800, 1200));
    c.hold_pulse_us      = c.min_pulse_us + 16'($urandom_range(0, 600));
    c.precharge_pulse_us = 16'($urandom);
    c.boost_pulse_us     = 16'($urandom);
    c.risk_limit         = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 2000));
    c.boost_time_ms      = 16'($urandom_range(0, 400));
    c.confirm_time_ms    = 16'($urandom_range(0, 300));
    c.ramp_step_us       = 16'($urandom_range(0, 100));
    return c;
  endfunction

  // Offer one tick after a random gap and hold it until it is taken.
  task automatic send_tick(input in_beat_t beat);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_tick(beat));
    ticks_sent++;
  endtask

  // Wait until every owed result has come back and the block is quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Registers change only with the block idle; all eight are written each time.
  task automatic program_cfg(input cfg_t c);
    drain_results();
    put_reg(REG_MIN_PULSE, c.min_pulse_us);
    put_reg(REG_HOLD_PULSE, c.hold_pulse_us);
    put_reg(REG_PRECHARGE_PULSE, c.precharge_pulse_us);
    put_reg(REG_BOOST_PULSE, c.boost_pulse_us);
    put_reg(REG_RISK_LIMIT, c.risk_limit);
    put_reg(REG_BOOST_TIME, c.boost_time_ms);
    put_reg(REG_CONFIRM_TIME, c.confirm_time_ms);
    put_reg(REG_RAMP_STEP, c.ramp_step_us);
    cfg_valid <= 1'b0;
    esc_cfg = c;
    settings_applied++;
  endtask

  // One wall mission with random content; some ticks are noise and some
  // missions break off early.
  task automatic send_mission();
    logic [3:0] route [8];
    int         span;
    route = '{PH_APPROACH, PH_PRECHARGE, PH_UP, PH_WALL, PH_CYLINDER, PH_DOWN,
              PH_RECOVERY, PH_GROUND};
    for (int leg = 0; leg < 8; leg++) begin
      if (route[leg] == PH_RECOVERY) span = $urandom_range(10, 50);
      else if (route[leg] == PH_WALL) span = $urandom_range(3, 15);
      else span = $urandom_range(1, 4);
      for (int k = 0; k < span; k++) begin
        if ($urandom_range(0, 99) < 8) begin
          send_tick(make_tick(4'($urandom), 16'($urandom), pick_dt()));
        end else begin
          send_tick(make_tick(route[leg], pick_risk(), pick_dt()));
        end
      end
      if ($urandom_range(0, 99) < 5) return;
    end
  endtask

  task automatic send_missions(input int unsigned count);
    int unsigned stop_at;
    stop_at = ticks_sent + count;
    while (ticks_sent < stop_at) send_mission();
  endtask

  // Arming holds idle until the delay is reached, then handles the phase.
  task automatic run_arming_delay();
    send_tick(make_tick(PH_TOP_CODE, 16'hFFFF, 16'd0));
    send_tick(make_tick(PH_WALL, 16'hFFFF, ARM_TIME_MS - 16'd1));
    send_tick(make_tick(PH_UP, 16'hFFFF, 16'd1));
  endtask

  // Boost runs on through the down phase and drops to hold at its time.
  task automatic run_boost_and_hold();
    send_tick(make_tick(PH_CYLINDER, 16'h0000, esc_cfg.boost_time_ms - 16'd1));
    send_tick(make_tick(PH_DOWN, 16'hFFFF, 16'd1));
    send_tick(make_tick(PH_DOWN, 16'hFFFF, 16'd5));
    send_tick(make_tick(PH_WALL, esc_cfg.risk_limit + 16'd1, 16'd0));
    send_tick(make_tick(PH_WALL, esc_cfg.risk_limit, 16'hFFFF));
    send_tick(make_tick(PH_WALL, esc_cfg.risk_limit, 16'd3));
  endtask

  // Precharge, off, failsafe with re-entry, and the unknown phase codes.
  task automatic run_phase_walk();
    send_tick(make_tick(PH_PRECHARGE, 16'd0, 16'd10));
    send_tick(make_tick(PH_APPROACH, 16'hFFFF, 16'd10));
    send_tick(make_tick(PH_GROUND, 16'd0, 16'hFFFF));
    send_tick(make_tick(PH_FAILSAFE, 16'hFFFF, 16'd7));
    send_tick(make_tick(PH_FAILSAFE, 16'd0, 16'd7));
    send_tick(make_tick(PH_OTHER, 16'd0, 16'd1));
    send_tick(make_tick(PH_TOP_CODE, 16'hFFFF, 16'hFFFF));
  endtask

  // Ground confirm, ramp entry, ramp steps and a wrapping confirm timer.
  task automatic run_recovery_ramp();
    send_tick(make_tick(PH_PRECHARGE, 16'd0, 16'd1));
    send_tick(make_tick(PH_RECOVERY, 16'd0, esc_cfg.confirm_time_ms - 16'd1));
    send_tick(make_tick(PH_RECOVERY, 16'd0, 16'd1));
    send_tick(make_tick(PH_RECOVERY, 16'd0, RAMP_PERIOD_MS - 16'd1));
    send_tick(make_tick(PH_RECOVERY, 16'hFFFF, 16'hFFFF));
  endtask

  // Register extremes, the end of the ramp and a wrapping ramp floor.
  task automatic run_config_corners();
    cfg_t corner;
    corner = '0;
    program_cfg(corner);
    send_missions(30);
    corner = '1;
    program_cfg(corner);
    send_missions(30);
    corner = CFG_RESET;
    corner.hold_pulse_us   = corner.min_pulse_us + corner.ramp_step_us;
    corner.confirm_time_ms = '0;
    program_cfg(corner);
    send_tick(make_tick(PH_RECOVERY, 16'd0, RAMP_PERIOD_MS));
    send_tick(make_tick(PH_RECOVERY, 16'd0, RAMP_PERIOD_MS));
    send_missions(20);
    corner = CFG_RESET;
    corner.min_pulse_us  = 16'hFFF0;
    corner.ramp_step_us  = 16'h0020;
    corner.hold_pulse_us = 16'h0100;
    program_cfg(corner);
    send_missions(30);
    corner = pick_mission_cfg();
    corner.boost_time_ms   = '0;
    corner.confirm_time_ms = 16'hFFFF;
    program_cfg(corner);
    send_missions(30);
  endtask

  // Random missions under each idling pattern, with a fresh setting each time.
  task automatic run_random_missions();
    int unsigned gaps [4];
    int unsigned stalls [4];
    gaps   = '{0, 45, 0, 21};
    stalls = '{0, 0, 45, 21};
    for (int p = 0; p < 4; p++) begin
      program_cfg(pick_mission_cfg());
      gap_pct   = gaps[p];
      stall_pct = stalls[p];
      send_missions(110);
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall.
  task automatic run_output_backpressure();
    drain_results();
    gap_pct   = 0;
    stall_pct = 0;
    hold_off_left = 80;
    send_missions(80);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_off_left != 0) begin
      out_stall <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: esc_mode %0d request %0d drive %0d",
               out_beat.esc_mode, out_beat.request_pulse_us, out_beat.drive_pulse_us);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_beat.esc_mode !== want.esc_mode) begin
          $error("esc_mode: expected %0d, got %0d", want.esc_mode, out_beat.esc_mode);
          mismatches++;
        end
        if (out_beat.request_pulse_us !== want.request_pulse_us) begin
          $error("request_pulse_us: expected %0d, got %0d",
                 want.request_pulse_us, out_beat.request_pulse_us);
          mismatches++;
        end
        if (out_beat.drive_pulse_us !== want.drive_pulse_us) begin
          $error("drive_pulse_us: expected %0d, got %0d",
                 want.drive_pulse_us, out_beat.drive_pulse_us);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run when no channel moves a beat for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("no beat moved for %0d cycles, %0d results still owed",
           WATCHDOG_LIMIT, expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    // The model starts from the reset state of the block.
    esc_cfg = CFG_RESET;
    esc_state = '0;
    if (OUTPUT_ENABLE) begin
      esc_state.mode = MODE_ARMING;
    end else begin
      esc_state.mode = MODE_OFF;
    end
    esc_state.pulse_us = CFG_RESET.min_pulse_us;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    run_arming_delay();
    run_boost_and_hold();
    run_phase_walk();
    run_recovery_ramp();
    run_config_corners();
    run_random_missions();
    run_output_backpressure();
    drain_results();

    $display("Checked %0d result beats from %0d ticks over %0d register settings.",
             results_checked, ticks_sent, settings_applied);
    $display("Covered arming, boost, hold, ramp, failsafe, unknown phases, gaps and stalls.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[fan_adhesion_esc_sequencer_core.f]
rtl/fanesc_pkg.sv
rtl/fanesc_step.sv
rtl/fan_adhesion_esc_sequencer_core.sv
rtl/fanesc_checker.sv
dv/tb_fan_adhesion_esc_sequencer_core.sv
